>>> rtl/anp_pkg.sv
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types and character codes for the ASCII number parser.
// ----------------------------------------------------------------------------
package anp_pkg;

    // width of the parsed value
    localparam int unsigned NUM_W  = 32;
    localparam int unsigned CHAR_W = 8;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F_UP = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_X_UP = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_F_LO = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_X_LO = 8'h78;

    // letter digits a..f / A..F carry 1..6 in the low nibble
    localparam logic [3:0] LETTER_OFFSET = 4'd9;

    // char_position saturation points
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    // word held in the input register
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] character;
    } t_in_word;

    // result word handed from the parse core to the output register
    typedef struct packed {
        logic             valid;
        logic             parsed_ok;
        logic [NUM_W-1:0] number;
    } t_result;

endpackage

>>> rtl/ascii_number_parser.sv
// ----------------------------------------------------------------------------
// ascii_number_parser
// Parses a zero-terminated ASCII decimal or 0x-prefixed hex string to 32 bits.
// ----------------------------------------------------------------------------
// One character is accepted every clock cycle unless o_in_stall holds it off.
// Each character passes through an input register, one pass of the
// multiply-by-base-and-add step, and a result register; a terminator's result
// word enters the result register when it is free. Only the terminator yields a
// result; the rate is set by that single multiply-add pass. allow_hex is
// written through its own port, which is always ready, and is reset to 1.
module ascii_number_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [anp_pkg::CHAR_W-1:0]    i_character,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_parsed_ok,
    output logic [anp_pkg::NUM_W-1:0]     o_number,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_allow_hex
);
    import anp_pkg::*;

    t_in_word in_word;
    t_result  result;
    logic     out_free;
    logic     advance;
    logic     r_allow_hex;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_hex <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_allow_hex <= i_cfg_allow_hex;
        end
    end

    // core moves a character on whenever the result slot can take a word
    assign advance = in_word.valid && out_free;

    anp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_character (i_character),
        .o_in_stall  (o_in_stall),
        .i_advance   (advance),
        .o_word      (in_word)
    );

    anp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_word      (in_word),
        .i_allow_hex (r_allow_hex),
        .o_result    (result)
    );

    anp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_free      (out_free),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_parsed_ok (o_parsed_ok),
        .o_number    (o_number)
    );

endmodule

>>> rtl/anp_in_reg.sv
// ----------------------------------------------------------------------------
// anp_in_reg
// Input register: holds one character until the parse core takes it.
// ----------------------------------------------------------------------------
module anp_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [anp_pkg::CHAR_W-1:0]    i_character,
    output logic                          o_in_stall,
    input  logic                          i_advance,
    output anp_pkg::t_in_word             o_word
);
    import anp_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [CHAR_W-1:0] r_char;
    logic              load;

    // register is free when empty or being drained this cycle
    assign o_in_stall = r_valid && !i_advance;
    assign load       = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_character;
        end
    end

    assign o_word.valid     = r_valid;
    assign o_word.character = r_char;

endmodule

>>> rtl/anp_core.sv
// ----------------------------------------------------------------------------
// anp_core
// Parse state and the single-pass step for one character.
// ----------------------------------------------------------------------------
module anp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  anp_pkg::t_in_word i_word,
    input  logic              i_allow_hex,
    output anp_pkg::t_result  o_result
);
    import anp_pkg::*;

    logic [NUM_W-1:0] r_acc;
    logic [NUM_W-1:0] n_acc;
    logic             r_hex_mode;
    logic             n_hex_mode;
    logic [1:0]       r_pos;
    logic [1:0]       n_pos;
    logic             r_first_zero;
    logic             n_first_zero;
    logic             r_invalid;
    logic             n_invalid;
    logic             r_pfx_no_digit;
    logic             n_pfx_no_digit;

    logic [CHAR_W-1:0] ch;
    logic              is_term;
    logic              is_dec;
    logic              is_hex_lo;
    logic              is_hex_up;
    logic              is_prefix;
    logic              take;
    logic              digit_ok;
    logic [3:0]        digit;
    logic [NUM_W-1:0]  acc_scaled;
    logic [NUM_W-1:0]  acc_next;

    assign ch = i_word.character;

    // character classes
    assign is_term   = (ch == CHAR_NUL);
    assign is_dec    = (ch >= CHAR_0)    && (ch <= CHAR_9);
    assign is_hex_lo = (ch >= CHAR_A_LO) && (ch <= CHAR_F_LO);
    assign is_hex_up = (ch >= CHAR_A_UP) && (ch <= CHAR_F_UP);
    assign is_prefix = (r_pos == POS_SECOND) && i_allow_hex && r_first_zero &&
                       ((ch == CHAR_X_LO) || (ch == CHAR_X_UP));
    assign take      = !r_invalid && !is_prefix;
    assign digit_ok  = is_dec || (r_hex_mode && (is_hex_lo || is_hex_up));
    assign digit     = is_dec ? ch[3:0] : (ch[3:0] + LETTER_OFFSET);

    // multiply by 16 or by 10 (8x + 2x), then add the digit
    assign acc_scaled = r_hex_mode ? {r_acc[NUM_W-5:0], 4'b0000}
                                   : ({r_acc[NUM_W-4:0], 3'b000} +
                                      {r_acc[NUM_W-2:0], 1'b0});
    assign acc_next   = acc_scaled + {{(NUM_W-4){1'b0}}, digit};

    // next state
    always_comb begin
        n_acc          = r_acc;
        n_hex_mode     = r_hex_mode;
        n_pos          = r_pos;
        n_first_zero   = r_first_zero;
        n_invalid      = r_invalid;
        n_pfx_no_digit = r_pfx_no_digit;
        if (is_term) begin
            n_acc          = '0;
            n_hex_mode     = 1'b0;
            n_pos          = POS_FIRST;
            n_first_zero   = 1'b0;
            n_invalid      = 1'b0;
            n_pfx_no_digit = 1'b0;
        end else begin
            if (!r_invalid && (r_pos == POS_FIRST)) begin
                n_first_zero = (ch == CHAR_0);
            end
            if (!r_invalid && is_prefix) begin
                n_hex_mode     = 1'b1;
                n_pfx_no_digit = 1'b1;
                n_acc          = '0;
            end else if (take) begin
                n_pfx_no_digit = 1'b0;
                if (digit_ok) begin
                    n_acc = acc_next;
                end else begin
                    n_invalid = 1'b1;
                end
            end
            if (r_pos != POS_LATER) begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc          <= '0;
            r_hex_mode     <= 1'b0;
            r_pos          <= POS_FIRST;
            r_first_zero   <= 1'b0;
            r_invalid      <= 1'b0;
            r_pfx_no_digit <= 1'b0;
        end else if (i_advance) begin
            r_acc          <= n_acc;
            r_hex_mode     <= n_hex_mode;
            r_pos          <= n_pos;
            r_first_zero   <= n_first_zero;
            r_invalid      <= n_invalid;
            r_pfx_no_digit <= n_pfx_no_digit;
        end
    end

    // result word at the terminator
    always_comb begin
        o_result.valid     = i_advance && is_term;
        o_result.parsed_ok = (r_pos != POS_FIRST) && !r_invalid && !r_pfx_no_digit;
        o_result.number    = o_result.parsed_ok ? r_acc : '0;
    end

endmodule

>>> rtl/anp_out_reg.sv
// ----------------------------------------------------------------------------
// anp_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module anp_out_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  anp_pkg::t_result           i_result,
    output logic                       o_free,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic                       o_parsed_ok,
    output logic [anp_pkg::NUM_W-1:0]  o_number
);
    import anp_pkg::*;

    logic             r_valid;
    logic             n_valid;
    logic             r_ok;
    logic [NUM_W-1:0] r_number;

    // free when empty or emptied at this edge
    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_ok     <= i_result.parsed_ok;
            r_number <= i_result.number;
        end
    end

    assign o_out_valid = r_valid;
    assign o_parsed_ok = r_ok;
    assign o_number    = r_number;

endmodule

>>> rtl/anp_checker.sv
// ----------------------------------------------------------------------------
// anp_checker
// Port-level checks for the ASCII number parser, bound to the top level.
// ----------------------------------------------------------------------------
module anp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_parsed_ok,
    input logic [anp_pkg::NUM_W-1:0]     o_number
);
    import anp_pkg::*;

    // a stalled result word stays offered
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_parsed_ok) && $stable(o_number)))
        else $error("result payload changed while stalled");

    // input back-pressure only comes from a full, stalled result register
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with result slot free");

    // a failed parse reports zero
    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_parsed_ok) |-> (o_number == '0))
        else $error("failed parse with non-zero number");

    // reset empties the result register
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ascii_number_parser anp_checker u_anp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_parsed_ok (o_parsed_ok),
    .o_number    (o_number)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ascii_number_parser.
// ----------------------------------------------------------------------------
// Feeds zero-terminated character strings through the input channel and
// mirrors the parse in a bench-side model of the string state. Each result
// word is checked against the oldest predicted one. A few short directed
// strings cover the corner cases. After them come phases of random strings,
// with allow_hex rewritten between phases. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import anp_pkg::*;

    localparam int unsigned CLK_PERIOD   = 20;
    localparam int unsigned PIPE_SETTLE  = 6;
    localparam int unsigned PHASE_CHARS  = 400;
    localparam int unsigned RUN_LIMIT_NS = 20_000_000;

    localparam logic [NUM_W-1:0] DEC_BASE  = 10;
    localparam logic [NUM_W-1:0] HEX_BASE  = 16;
    localparam logic [3:0]       DIGIT_TEN = 4'd10;

    typedef struct {
        logic             parsed_ok;
        logic [NUM_W-1:0] number;
    } t_parse_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    // dut ports
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CHAR_W-1:0] i_character;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_parsed_ok;
    logic [NUM_W-1:0]  o_number;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_allow_hex;

    // bench-side copy of the string state and the register
    logic [NUM_W-1:0]  acc_value;
    logic              hex_active;
    logic [1:0]        char_pos;
    logic              lead_zero;
    logic              str_invalid;
    logic              prefix_open;
    logic              allow_hex_q;

    t_parse_result     pending_results[$];
    int unsigned       mismatch_count = 0;
    int unsigned       chars_sent     = 0;
    int unsigned       burst_left     = 0;

    t_stall_mode       stall_mode = STALL_NONE;
    int unsigned       stall_hold = 0;
    logic [1:0]        stall_tick = '0;

    ascii_number_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_character     (i_character),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_parsed_ok     (o_parsed_ok),
        .o_number        (o_number),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_allow_hex (i_cfg_allow_hex)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // string state back to empty
    function automatic void clear_string();
        acc_value   = '0;
        hex_active  = 1'b0;
        char_pos    = POS_FIRST;
        lead_zero   = 1'b0;
        str_invalid = 1'b0;
        prefix_open = 1'b0;
    endfunction

    // one character on the digit path of the current base
    function automatic void accumulate_digit(input logic [CHAR_W-1:0] c);
        logic [3:0] digit;
        logic       is_digit;
        prefix_open = 1'b0;
        is_digit    = 1'b1;
        digit       = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            digit = 4'(c - CHAR_0);
        end else if (hex_active && c >= CHAR_A_LO && c <= CHAR_F_LO) begin
            digit = 4'(c - CHAR_A_LO) + DIGIT_TEN;
        end else if (hex_active && c >= CHAR_A_UP && c <= CHAR_F_UP) begin
            digit = 4'(c - CHAR_A_UP) + DIGIT_TEN;
        end else begin
            is_digit = 1'b0;
        end
        if (!is_digit) begin
            str_invalid = 1'b1;
        end else begin
            acc_value = acc_value * (hex_active ? HEX_BASE : DEC_BASE) + NUM_W'(digit);
        end
    endfunction

    // advance the string state by one accepted word, queue a result on the terminator
    function automatic void parse_char(input logic [CHAR_W-1:0] c);
        t_parse_result r;
        if (c == CHAR_NUL) begin
            r.parsed_ok = (char_pos != POS_FIRST) && !str_invalid && !prefix_open;
            r.number    = r.parsed_ok ? acc_value : '0;
            pending_results.push_back(r);
            clear_string();
            return;
        end
        if (!str_invalid) begin
            if (char_pos == POS_FIRST) begin
                lead_zero = (c == CHAR_0);
                accumulate_digit(c);
            end else if (char_pos == POS_SECOND && allow_hex_q && lead_zero &&
                         (c == CHAR_X_LO || c == CHAR_X_UP)) begin
                hex_active  = 1'b1;
                prefix_open = 1'b1;
                acc_value   = '0;
            end else begin
                accumulate_digit(c);
            end
        end
        if (char_pos != POS_LATER) begin
            char_pos = char_pos + 2'd1;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] rand_hex_char();
        case ($urandom_range(0, 2))
            0:       return CHAR_0 + CHAR_W'($urandom_range(0, 9));
            1:       return CHAR_A_LO + CHAR_W'($urandom_range(0, 5));
            default: return CHAR_A_UP + CHAR_W'($urandom_range(0, 5));
        endcase
    endfunction

    // one word on the input channel, sender idles in bursts
    task automatic send_char(input logic [CHAR_W-1:0] c);
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_character <= c;
        do @(posedge i_clk); while (o_in_stall);
        parse_char(c);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_in_valid  <= 1'b0;
            i_character <= CHAR_W'($urandom);
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_char(CHAR_W'(s[k]));
        end
        send_char(CHAR_NUL);
    endtask

    // stop sending and wait until the pipe has nothing left in it
    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_allow_hex(input logic v);
        drain_pipe();
        @(negedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_allow_hex <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        allow_hex_q = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stall pattern, mode changes every so often
    always @(negedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(16, 200);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_COIN:     i_out_stall <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: i_out_stall <= (stall_tick != 2'd0);
            default:        i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
        stall_tick <= stall_tick + 2'd1;
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_parse_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with none expected: parsed_ok %0d number %0h",
                       o_parsed_ok, o_number);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_parsed_ok !== want.parsed_ok) begin
                    $error("parsed_ok: expected %0d, actual %0d", want.parsed_ok, o_parsed_ok);
                    mismatch_count++;
                end
                if (o_number !== want.number) begin
                    $error("number: expected %0h, actual %0h", want.number, o_number);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic apply_reset();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_character     = '0;
        i_out_stall     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_allow_hex = 1'b0;
        allow_hex_q     = 1'b1;
        clear_string();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // empty string, lone zero, plain decimal
    task automatic test_decimal_strings();
        send_char(CHAR_NUL);
        send_text("0");
        send_text("99");
    endtask

    // both prefix cases, mixed-case letters, bare prefix
    task automatic test_hex_prefix();
        send_text("0XfA");
        send_text("0x");
    endtask

    // letters in decimal, x not after a zero, junk then digits, top byte
    task automatic test_malformed_strings();
        send_text("9a");
        send_text("1x");
        send_text("#5");
        send_char(8'hFF);
        send_char(CHAR_NUL);
    endtask

    // prefix with hex off, and the register changed after the first character
    task automatic test_allow_hex_switch();
        write_allow_hex(1'b0);
        send_text("0x5");
        send_char(CHAR_0);
        write_allow_hex(1'b1);
        send_text("x5");
        send_char(CHAR_0);
        write_allow_hex(1'b0);
        send_text("X5");
        write_allow_hex(1'b1);
    endtask

    // phases of random strings, mostly well formed, allow_hex set per phase
    task automatic test_random_strings();
        logic [CHAR_W-1:0] text[$];
        int unsigned       phase_end;
        int unsigned       len;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       write_allow_hex(1'b0);
                1:       write_allow_hex(1'b1);
                default: write_allow_hex(1'($urandom_range(0, 1)));
            endcase
            phase_end = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end) begin
                text.delete();
                len = $urandom_range(1, 12);
                case ($urandom_range(0, 9))
                    // decimal, long ones wrap past 32 bits
                    0, 1, 2, 3: begin
                        for (int k = 0; k < len; k++) begin
                            text.push_back(CHAR_0 + CHAR_W'($urandom_range(0, 9)));
                        end
                    end
                    // prefixed hex
                    4, 5, 6: begin
                        text.push_back(CHAR_0);
                        text.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
                        for (int k = 0; k < len; k++) begin
                            text.push_back(rand_hex_char());
                        end
                    end
                    // hex digits without a prefix
                    7: begin
                        for (int k = 0; k < len; k++) begin
                            text.push_back(rand_hex_char());
                        end
                    end
                    // broken: one corrupted character, or a bare prefix
                    8: begin
                        if ($urandom_range(0, 2) == 0) begin
                            text.push_back(CHAR_0);
                            text.push_back(CHAR_X_LO);
                        end else begin
                            text.push_back(CHAR_0);
                            for (int k = 0; k < len; k++) begin
                                text.push_back(rand_hex_char());
                            end
                            text[$urandom_range(0, text.size() - 1)] =
                                CHAR_W'($urandom_range(1, 255));
                        end
                    end
                    // noise bytes, possibly empty
                    default: begin
                        repeat ($urandom_range(0, 5)) begin
                            text.push_back(CHAR_W'($urandom_range(1, 255)));
                        end
                    end
                endcase
                foreach (text[k]) begin
                    send_char(text[k]);
                end
                send_char(CHAR_NUL);
                if ($urandom_range(0, 59) == 0) begin
                    drain_pipe();
                end
            end
        end
    endtask

    initial begin
        apply_reset();
        test_decimal_strings();
        test_hex_prefix();
        test_malformed_strings();
        test_allow_hex_switch();
        test_random_strings();
        drain_pipe();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/anp_pkg.sv
rtl/anp_in_reg.sv
rtl/anp_core.sv
rtl/anp_out_reg.sv
rtl/ascii_number_parser.sv
rtl/anp_checker.sv
sim/tb.sv
